@@ design/wsfe_pkg.sv @@
package wsfe_pkg;

  localparam int LEN_BITS = 63;
  localparam int Q_DEPTH  = 2;
  localparam int Q_PTR_W  = $clog2(Q_DEPTH);
  localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

  // code byte, 64-bit length, mask key
  localparam int HDR_BITS = 104;
  localparam int CNT_W    = 4;

  localparam logic [7:0]  FIN_TEXT      = 8'h81;
  localparam logic [7:0]  MASK_BIT      = 8'h80;
  localparam logic [7:0]  LEN_SHORT_MAX = 8'd125;
  localparam logic [15:0] LEN_MID_MAX   = 16'hFFFF;
  localparam logic [7:0]  CODE_16       = 8'd126;
  localparam logic [7:0]  CODE_64       = 8'd127;

  // header bytes still due after the leading FIN_TEXT byte
  localparam logic [CNT_W-1:0] N_SHORT = 4'd5;
  localparam logic [CNT_W-1:0] N_MID   = 4'd7;
  localparam logic [CNT_W-1:0] N_LONG  = 4'd13;

  typedef enum logic {
    OP_START = 1'b0,
    OP_DATA  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    LEN_SHORT = 2'd0,
    LEN_MID   = 2'd1,
    LEN_LONG  = 2'd2
  } len_cls_t;

  typedef struct packed {
    logic                is_start;
    len_cls_t            cls;
    logic                zero;
    logic [LEN_BITS-1:0] len;
    logic [31:0]         key;
    logic [7:0]          data;
    logic                last;
    logic                err;
  } job_t;

  function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = key[31:24];
      2'd1:    b = key[23:16];
      2'd2:    b = key[15:8];
      default: b = key[7:0];
    endcase
    return b;
  endfunction

endpackage

@@ design/websocket_frame_encoder.sv @@
// channel | handshake              | payload
// in      | in_valid / in_ready    | in_operation, in_message_length, in_mask_key,
//         |                        | in_payload_byte
// out     | out_valid / out_ready  | out_byte, out_frame_last, out_is_header, out_status
//
// A data item gives one output byte and the block takes one per cycle while out_ready is high.
// A start item gives 6, 8 or 14 header bytes, one per cycle while out_ready is high, from the header
// shift register in the back end; the next queued item follows with no gap.
// Input is taken while the two-entry job queue has room.
// Reset (rst_n low, synchronous) clears frame state, the queue and the output.
// Output stalls fill the queue and then drop in_ready; in_ready is not combinationally tied to out_ready.
module websocket_frame_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [62:0] in_message_length,
  input  logic [31:0] in_mask_key,
  input  logic [7:0]  in_payload_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_frame_last,
  output logic        out_is_header,
  output logic        out_status
);

  wsfe_pkg::job_t push_job;
  wsfe_pkg::job_t head;
  logic           push;
  logic           pop;
  logic           full;
  logic           empty;

  assign in_ready = !full;

  wsfe_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_message_length (in_message_length),
    .in_mask_key       (in_mask_key),
    .in_payload_byte   (in_payload_byte),
    .push              (push),
    .job               (push_job)
  );

  wsfe_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .full     (full),
    .empty    (empty),
    .head     (head)
  );

  wsfe_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (empty),
    .q_head         (head),
    .q_pop          (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_frame_last (out_frame_last),
    .out_is_header  (out_is_header),
    .out_status     (out_status)
  );

endmodule

@@ design/wsfe_front.sv @@
module wsfe_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic                      in_operation,
  input  logic [62:0]               in_message_length,
  input  logic [31:0]               in_mask_key,
  input  logic [7:0]                in_payload_byte,
  output logic                      push,
  output wsfe_pkg::job_t            job
);

  logic [wsfe_pkg::LEN_BITS-1:0] rem_r, rem_nxt;
  logic [1:0]                    midx_r, midx_nxt;
  logic [31:0]                   key_r, key_nxt;
  logic                          open_r, open_nxt;
  logic [wsfe_pkg::LEN_BITS-1:0] len;
  logic                          is_last;

  assign push    = in_valid && in_ready;
  assign len     = in_message_length[wsfe_pkg::LEN_BITS-1:0];
  assign is_last = (rem_r == wsfe_pkg::LEN_BITS'(1));

  always_comb begin
    job          = '0;
    job.is_start = (in_operation == wsfe_pkg::OP_START);
    job.len      = len;
    job.key      = in_mask_key;
    job.zero     = (len == '0);
    if (len <= wsfe_pkg::LEN_BITS'(wsfe_pkg::LEN_SHORT_MAX)) begin
      job.cls = wsfe_pkg::LEN_SHORT;
    end else if (len <= wsfe_pkg::LEN_BITS'(wsfe_pkg::LEN_MID_MAX)) begin
      job.cls = wsfe_pkg::LEN_MID;
    end else begin
      job.cls = wsfe_pkg::LEN_LONG;
    end
    job.err  = !open_r;
    job.data = open_r ? (in_payload_byte ^ wsfe_pkg::key_byte(key_r, midx_r)) : 8'h00;
    job.last = open_r && is_last;
  end

  always_comb begin
    rem_nxt  = rem_r;
    midx_nxt = midx_r;
    key_nxt  = key_r;
    open_nxt = open_r;
    if (push) begin
      if (in_operation == wsfe_pkg::OP_START) begin
        rem_nxt  = len;
        midx_nxt = 2'd0;
        key_nxt  = in_mask_key;
        open_nxt = (len != '0);
      end else if (open_r) begin
        rem_nxt  = rem_r - wsfe_pkg::LEN_BITS'(1);
        midx_nxt = midx_r + 2'd1;
        open_nxt = !is_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= '0;
      midx_r <= '0;
      key_r  <= '0;
      open_r <= 1'b0;
    end else begin
      rem_r  <= rem_nxt;
      midx_r <= midx_nxt;
      key_r  <= key_nxt;
      open_r <= open_nxt;
    end
  end

endmodule

@@ design/wsfe_queue.sv @@
module wsfe_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  wsfe_pkg::job_t push_job,
  input  logic           pop,
  output logic           full,
  output logic           empty,
  output wsfe_pkg::job_t head
);

  wsfe_pkg::job_t                 mem_r [wsfe_pkg::Q_DEPTH];
  logic [wsfe_pkg::Q_PTR_W-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [wsfe_pkg::Q_CNT_W-1:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == wsfe_pkg::Q_CNT_W'(wsfe_pkg::Q_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_r];

  function automatic logic [wsfe_pkg::Q_PTR_W-1:0] bump(
    input logic [wsfe_pkg::Q_PTR_W-1:0] p);
    logic [wsfe_pkg::Q_PTR_W-1:0] q;
    if (p == wsfe_pkg::Q_PTR_W'(wsfe_pkg::Q_DEPTH - 1)) q = '0;
    else q = p + wsfe_pkg::Q_PTR_W'(1);
    return q;
  endfunction

  always_comb begin
    wr_nxt  = (push && !full) ? bump(wr_r) : wr_r;
    rd_nxt  = (pop && !empty) ? bump(rd_r) : rd_r;
    cnt_nxt = cnt_r;
    if ((push && !full) && !(pop && !empty)) cnt_nxt = cnt_r + wsfe_pkg::Q_CNT_W'(1);
    else if (!(push && !full) && (pop && !empty)) cnt_nxt = cnt_r - wsfe_pkg::Q_CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (push && !full) mem_r[wr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ design/wsfe_back.sv @@
module wsfe_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  wsfe_pkg::job_t q_head,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           out_frame_last,
  output logic           out_is_header,
  output logic           out_status
);

  logic [wsfe_pkg::HDR_BITS-1:0] sh_r, sh_nxt;
  logic [wsfe_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                          zero_r, zero_nxt;
  logic                          vld_r, vld_nxt;
  logic [7:0]                    byte_r, byte_nxt;
  logic                          last_r, last_nxt;
  logic                          hdr_r, hdr_nxt;
  logic                          st_r, st_nxt;
  logic                          take;
  logic [63:0]                   len64;

  assign take  = !vld_r || out_ready;
  assign len64 = {{(64 - wsfe_pkg::LEN_BITS){1'b0}}, q_head.len};
  assign q_pop = take && (cnt_r == '0) && !q_empty;

  always_comb begin
    sh_nxt   = sh_r;
    cnt_nxt  = cnt_r;
    zero_nxt = zero_r;
    vld_nxt  = vld_r;
    byte_nxt = byte_r;
    last_nxt = last_r;
    hdr_nxt  = hdr_r;
    st_nxt   = st_r;
    if (take) begin
      vld_nxt = 1'b0;
      if (cnt_r != '0) begin
        // shift out the next header byte
        vld_nxt  = 1'b1;
        byte_nxt = sh_r[wsfe_pkg::HDR_BITS-1 -: 8];
        last_nxt = (cnt_r == wsfe_pkg::CNT_W'(1)) && zero_r;
        hdr_nxt  = 1'b1;
        st_nxt   = 1'b0;
        sh_nxt   = sh_r << 8;
        cnt_nxt  = cnt_r - wsfe_pkg::CNT_W'(1);
      end else if (!q_empty) begin
        vld_nxt = 1'b1;
        if (q_head.is_start) begin
          byte_nxt = wsfe_pkg::FIN_TEXT;
          last_nxt = 1'b0;
          hdr_nxt  = 1'b1;
          st_nxt   = 1'b0;
          zero_nxt = q_head.zero;
          case (q_head.cls)
            wsfe_pkg::LEN_SHORT: begin
              sh_nxt  = {wsfe_pkg::MASK_BIT | {1'b0, len64[6:0]}, q_head.key, 64'h0};
              cnt_nxt = wsfe_pkg::N_SHORT;
            end
            wsfe_pkg::LEN_MID: begin
              sh_nxt  = {wsfe_pkg::MASK_BIT | wsfe_pkg::CODE_16, len64[15:0],
                         q_head.key, 48'h0};
              cnt_nxt = wsfe_pkg::N_MID;
            end
            default: begin
              sh_nxt  = {wsfe_pkg::MASK_BIT | wsfe_pkg::CODE_64, len64, q_head.key};
              cnt_nxt = wsfe_pkg::N_LONG;
            end
          endcase
        end else begin
          byte_nxt = q_head.data;
          last_nxt = q_head.last;
          hdr_nxt  = 1'b0;
          st_nxt   = q_head.err;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      vld_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r   <= sh_nxt;
    zero_r <= zero_nxt;
    byte_r <= byte_nxt;
    last_r <= last_nxt;
    hdr_r  <= hdr_nxt;
    st_r   <= st_nxt;
  end

  assign out_valid      = vld_r;
  assign out_byte       = byte_r;
  assign out_frame_last = last_r;
  assign out_is_header  = hdr_r;
  assign out_status     = st_r;

endmodule

@@ design/wsfe_checker.sv @@
module wsfe_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic        out_frame_last,
  input logic        out_is_header,
  input logic        out_status
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
      $stable(out_frame_last) && $stable(out_is_header) && $stable(out_status))
    else $error("stalled result changed");

  // an error result carries nothing else
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_byte == 8'h00 && !out_frame_last && !out_is_header)
    else $error("error result not clean");

  // drop the output the cycle after reset
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind websocket_frame_encoder wsfe_checker u_wsfe_checker (.*);
